// File: design/sfx_pkg.sv
package sfx_pkg;

	// Parse phases of the file walker.
	localparam logic [3:0] PH_MAGIC     = 4'd0;
	localparam logic [3:0] PH_HDR_LEN   = 4'd1;
	localparam logic [3:0] PH_SKIP      = 4'd2;
	localparam logic [3:0] PH_CHUNK_ID  = 4'd3;
	localparam logic [3:0] PH_CHUNK_LEN = 4'd4;
	localparam logic [3:0] PH_DELTA     = 4'd5;
	localparam logic [3:0] PH_EVENT     = 4'd6;
	localparam logic [3:0] PH_SX_LEN    = 4'd7;
	localparam logic [3:0] PH_SX_DATA   = 4'd8;
	localparam logic [3:0] PH_META_TYPE = 4'd9;
	localparam logic [3:0] PH_META_LEN  = 4'd10;
	localparam logic [3:0] PH_META_SKIP = 4'd11;
	localparam logic [3:0] PH_REJECT    = 4'd12;

	// End-of-stream status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_MIDI = 2'd1;
	localparam logic [1:0] ST_TRUNC    = 2'd2;

	// Event and meta bytes.
	localparam logic [7:0] EV_SYSEX     = 8'hF0;
	localparam logic [7:0] EV_SYSEX_END = 8'hF7;
	localparam logic [7:0] EV_SYSEX_ALT = 8'hF8;
	localparam logic [7:0] EV_META      = 8'hFF;
	localparam logic [7:0] META_EOT     = 8'h2F;

	// Chunk tags "MThd" and "MTrk".
	localparam logic [7:0] HDR_TAG [4] = '{8'h4D, 8'h54, 8'h68, 8'h64};
	localparam logic [7:0] TRK_TAG [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

	// Depth of the result buffer.
	localparam int RES_DEPTH = 2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       message_end;
		logic       message_abort;
		logic       report_valid;
		logic [1:0] status;
	} result_t;

endpackage

// File: design/sfx_parser.sv
module sfx_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  sfx_pkg::item_t  item,
	output logic            res_valid,
	output sfx_pkg::result_t res,
	output logic [3:0]      phase
);

	logic [3:0]  phase_q, phase_d;
	logic [1:0]  pos_q, pos_d;
	logic        idm_q, idm_d;
	logic        trk_q, trk_d;
	logic [31:0] skip_q, skip_d;
	logic        eot_q, eot_d;
	logic        mfail_q, mfail_d;

	logic [7:0]  b;
	logic [7:0]  tag_byte;
	logic        idm_n;
	logic [31:0] shifted;
	logic [31:0] dec;
	logic [1:0]  eos_status;

	assign b       = item.in_byte;
	assign tag_byte = (phase_q == sfx_pkg::PH_MAGIC) ? sfx_pkg::HDR_TAG[pos_q]
		: sfx_pkg::TRK_TAG[pos_q];
	assign idm_n   = idm_q & (b == tag_byte);
	assign shifted = {skip_q[23:0], b};
	assign dec     = skip_q - 32'd1;
	assign phase   = phase_q;

	always_comb begin
		case (phase_q)
			sfx_pkg::PH_MAGIC:     eos_status = sfx_pkg::ST_NOT_MIDI;
			sfx_pkg::PH_HDR_LEN,
			sfx_pkg::PH_SKIP,
			sfx_pkg::PH_CHUNK_ID,
			sfx_pkg::PH_EVENT:     eos_status = sfx_pkg::ST_OK;
			sfx_pkg::PH_CHUNK_LEN: eos_status = trk_q ? sfx_pkg::ST_TRUNC : sfx_pkg::ST_OK;
			sfx_pkg::PH_META_LEN:  eos_status = eot_q ? sfx_pkg::ST_OK : sfx_pkg::ST_TRUNC;
			sfx_pkg::PH_DELTA,
			sfx_pkg::PH_SX_LEN,
			sfx_pkg::PH_SX_DATA,
			sfx_pkg::PH_META_TYPE,
			sfx_pkg::PH_META_SKIP: eos_status = sfx_pkg::ST_TRUNC;
			default:               eos_status = sfx_pkg::ST_NOT_MIDI;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		idm_d     = idm_q;
		trk_d     = trk_q;
		skip_d    = skip_q;
		eot_d     = eot_q;
		mfail_d   = mfail_q;
		res_valid = 1'b0;
		res       = '0;
		if (item.end_of_stream) begin
			// Report the status, abort any open message and return to reset state.
			res_valid         = 1'b1;
			res.report_valid  = 1'b1;
			res.status        = mfail_q ? sfx_pkg::ST_NOT_MIDI : eos_status;
			res.message_abort = (phase_q == sfx_pkg::PH_SX_LEN) ||
				(phase_q == sfx_pkg::PH_SX_DATA);
			phase_d = sfx_pkg::PH_MAGIC;
			pos_d   = 2'd0;
			idm_d   = 1'b1;
			trk_d   = 1'b0;
			skip_d  = '0;
			eot_d   = 1'b0;
			mfail_d = 1'b0;
		end else begin
			case (phase_q)
				sfx_pkg::PH_MAGIC, sfx_pkg::PH_CHUNK_ID: begin
					if (pos_q == 2'd3) begin
						pos_d  = 2'd0;
						skip_d = '0;
						idm_d  = 1'b1;
						if (phase_q == sfx_pkg::PH_MAGIC) begin
							if (idm_n) begin
								phase_d = sfx_pkg::PH_HDR_LEN;
							end else begin
								mfail_d = 1'b1;
								phase_d = sfx_pkg::PH_REJECT;
							end
						end else begin
							trk_d   = idm_n;
							phase_d = sfx_pkg::PH_CHUNK_LEN;
						end
					end else begin
						pos_d = pos_q + 2'd1;
						idm_d = idm_n;
					end
				end
				sfx_pkg::PH_HDR_LEN, sfx_pkg::PH_CHUNK_LEN: begin
					skip_d = shifted;
					if (pos_q == 2'd3) begin
						pos_d = 2'd0;
						if (phase_q == sfx_pkg::PH_CHUNK_LEN && trk_q) begin
							skip_d  = '0;
							phase_d = sfx_pkg::PH_DELTA;
						end else begin
							phase_d = (shifted == 32'd0) ? sfx_pkg::PH_CHUNK_ID
								: sfx_pkg::PH_SKIP;
						end
					end else begin
						pos_d = pos_q + 2'd1;
					end
				end
				sfx_pkg::PH_SKIP: begin
					skip_d = dec;
					if (dec == 32'd0) begin
						phase_d = sfx_pkg::PH_CHUNK_ID;
					end
				end
				sfx_pkg::PH_DELTA: begin
					if (!b[7]) begin
						phase_d = sfx_pkg::PH_EVENT;
					end
				end
				sfx_pkg::PH_EVENT: begin
					if (b == sfx_pkg::EV_SYSEX) begin
						phase_d      = sfx_pkg::PH_SX_LEN;
						res_valid    = 1'b1;
						res.out_byte = sfx_pkg::EV_SYSEX;
					end else if (b == sfx_pkg::EV_META) begin
						phase_d = sfx_pkg::PH_META_TYPE;
					end else begin
						phase_d = sfx_pkg::PH_DELTA;
					end
				end
				sfx_pkg::PH_SX_LEN: begin
					if (!b[7]) begin
						phase_d = sfx_pkg::PH_SX_DATA;
					end
				end
				sfx_pkg::PH_SX_DATA: begin
					res_valid = 1'b1;
					if (b == sfx_pkg::EV_SYSEX_END || b == sfx_pkg::EV_SYSEX_ALT) begin
						phase_d         = sfx_pkg::PH_DELTA;
						res.out_byte    = sfx_pkg::EV_SYSEX_END;
						res.message_end = 1'b1;
					end else begin
						res.out_byte = b;
					end
				end
				sfx_pkg::PH_META_TYPE: begin
					eot_d   = (b == sfx_pkg::META_EOT);
					phase_d = sfx_pkg::PH_META_LEN;
				end
				sfx_pkg::PH_META_LEN: begin
					if (eot_q) begin
						eot_d   = 1'b0;
						pos_d   = 2'd0;
						idm_d   = 1'b1;
						phase_d = sfx_pkg::PH_CHUNK_ID;
					end else begin
						skip_d  = {24'd0, b};
						phase_d = (b == 8'd0) ? sfx_pkg::PH_DELTA : sfx_pkg::PH_META_SKIP;
					end
				end
				sfx_pkg::PH_META_SKIP: begin
					skip_d = dec;
					if (dec == 32'd0) begin
						phase_d = sfx_pkg::PH_DELTA;
					end
				end
				default: begin
					mfail_d = 1'b1;
					phase_d = sfx_pkg::PH_REJECT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfx_pkg::PH_MAGIC;
			pos_q   <= 2'd0;
			idm_q   <= 1'b1;
			trk_q   <= 1'b0;
			skip_q  <= '0;
			eot_q   <= 1'b0;
			mfail_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			idm_q   <= idm_d;
			trk_q   <= trk_d;
			skip_q  <= skip_d;
			eot_q   <= eot_d;
			mfail_q <= mfail_d;
		end
	end

endmodule

// File: design/sfx_res_buf.sv
module sfx_res_buf #(
	parameter int DEPTH = sfx_pkg::RES_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sfx_pkg::result_t push_data,
	output logic             space,
	output logic             out_valid,
	input  logic             out_stall,
	output sfx_pkg::result_t out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sfx_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             pop;

	assign space     = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid & ~out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: design/midi_file_sysex_extractor_core.sv
// Throughput: one item per clock while the result buffer has space; the input register,
// the single-pass parser and a two-entry result buffer keep the input open while a
// finished result waits downstream.
// Reset: arst_n clears the parse state to the start of a new file and empties the
// input register and result buffer at once; no clearing pass is needed.
module midi_file_sysex_extractor_core #(
	parameter int RES_DEPTH = sfx_pkg::RES_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sfx_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output sfx_pkg::result_t result
);

	// Input register: holds one item until the parser can step on it.
	sfx_pkg::item_t   item_s1;
	logic             valid_s1;

	logic             buf_space;
	logic             consume;
	logic             res_valid;
	sfx_pkg::result_t res;
	logic [3:0]       phase;

	// The parser steps on the registered item whenever the result buffer has a free
	// slot, whether or not the item makes a result.
	assign consume    = valid_s1 & buf_space;
	assign item_stall = valid_s1 & ~buf_space;

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Parser: phase register, tag check, length counter and the result it makes.
	sfx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (consume),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res),
		.phase     (phase)
	);

	// Result buffer: separates the parser from a stalling receiver.
	sfx_res_buf #(
		.DEPTH (RES_DEPTH)
	) u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (consume & res_valid),
		.push_data (res),
		.space     (buf_space),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (result)
	);

	// The input is only held back while a registered item is waiting.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with no item held");

	// An end-of-stream item always returns the parser to the header tag phase.
	a_eos_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && item_s1.end_of_stream) |=> (phase == sfx_pkg::PH_MAGIC))
		else $error("parser did not restart after end of stream");

	// Message bytes carry no status; reports carry no message end.
	a_result_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.report_valid ? !result.message_end
			: (result.status == sfx_pkg::ST_OK && !result.message_abort)))
		else $error("result mixes message and report fields");

endmodule
